/* sv/rbds_pkg.sv */
// rbds_pkg: shared constants, types and channel arithmetic for the 2x2 rgba8 downsampler
`default_nettype none

package rbds_pkg;

	localparam int MAX_WIDTH_DEF = 4096;
	localparam int CFG_W         = 13;
	localparam int MIN_WIDTH     = 2;
	localparam logic [CFG_W-1:0] LINE_WIDTH_RST = 13'd512;

	localparam int PIX_W   = 32;
	localparam int CH_W    = 8;
	localparam int NUM_CH  = 4;
	localparam int SUM_W   = 9;
	localparam int PSUM_W  = NUM_CH * SUM_W;

	localparam int OP_Q_DEPTH  = 4;
	localparam int OUT_Q_DEPTH = 4;

	// one classified pixel pair handed from front to back
	typedef struct packed {
		logic              emit;     // odd row: read, add, emit; else store
		logic              row_end;
		logic [PSUM_W-1:0] psum;
	} op_t;

	// four 9-bit channel sums of two pixels
	function automatic logic [PSUM_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		logic [PSUM_W-1:0] s;
		s = '0;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			s[ch*SUM_W +: SUM_W] = {1'b0, a[ch*CH_W +: CH_W]} + {1'b0, b[ch*CH_W +: CH_W]};
		end
		return s;
	endfunction

	// add two pair sums per channel and divide by four
	function automatic logic [PIX_W-1:0] avg4(input logic [PSUM_W-1:0] prev,
		input logic [PSUM_W-1:0] ps);
		logic [PIX_W-1:0]  res;
		logic [SUM_W:0]    t;
		res = '0;
		for (int ch = 0; ch < NUM_CH; ch++) begin
			t = {1'b0, prev[ch*SUM_W +: SUM_W]} + {1'b0, ps[ch*SUM_W +: SUM_W]};
			res[ch*CH_W +: CH_W] = t[SUM_W:2];
		end
		return res;
	endfunction

endpackage

`default_nettype wire

/* sv/rbds_fifo.sv */
// rbds_fifo: small register-based first-in first-out queue
`default_nettype none

module rbds_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       pop,
	output logic      [WIDTH-1:0]           rdata,
	output logic                            full,
	output logic                            empty,
	output logic      [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = store_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

/* sv/rbds_front.sv */
// rbds_front: pixel intake, width register, column tracking and pair classification
`default_nettype none

module rbds_front #(
	parameter int MAX_WIDTH = rbds_pkg::MAX_WIDTH_DEF,
	parameter int IDX_W     = 11
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [rbds_pkg::CFG_W-1:0]        line_width,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [rbds_pkg::PIX_W-1:0]        pixel_in,
	input  wire logic                              frame_start,
	input  wire logic                              op_full,
	output logic                                   op_push,
	output logic [IDX_W-1:0]                       op_idx,
	output rbds_pkg::op_t                          op
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int W_W   = $clog2(MAX_WIDTH + 1);
	localparam int CMP_W = ((W_W > rbds_pkg::CFG_W) ? W_W : rbds_pkg::CFG_W) + 1;
	localparam int NXT_W = W_W + 1;

	logic [rbds_pkg::CFG_W-1:0] line_width_q;
	logic [COL_W-1:0]           col_q;
	logic                       odd_q;
	logic [rbds_pkg::PIX_W-1:0] left_q;

	logic [CMP_W-1:0] lw_ext;
	logic [CMP_W-1:0] w_clamp;
	logic [W_W-1:0]   w_eff;
	logic             accept;
	logic [COL_W-1:0] col;
	logic             odd;
	logic [NXT_W-1:0] col_ext;
	logic             last_col;

	assign cfg_ready = 1'b1;
	assign full      = op_full;
	assign accept    = push && !op_full;

	// clamp width to the supported range
	always_comb begin
		lw_ext = CMP_W'(line_width_q);
		if (lw_ext < CMP_W'(rbds_pkg::MIN_WIDTH)) begin
			w_clamp = CMP_W'(rbds_pkg::MIN_WIDTH);
		end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
			w_clamp = CMP_W'(MAX_WIDTH);
		end else begin
			w_clamp = lw_ext;
		end
		w_eff = W_W'(w_clamp);
	end

	assign col      = frame_start ? '0 : col_q;
	assign odd      = frame_start ? 1'b0 : odd_q;
	assign col_ext  = NXT_W'(col);
	assign last_col = (col_ext + NXT_W'(1)) >= NXT_W'(w_eff);

	assign op_push    = accept && col[0];
	assign op_idx     = IDX_W'(col >> 1);
	assign op.emit    = odd;
	assign op.row_end = (col_ext + NXT_W'(2)) >= NXT_W'(w_eff);
	assign op.psum    = rbds_pkg::pair_sum(left_q, pixel_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= rbds_pkg::LINE_WIDTH_RST;
			col_q        <= '0;
			odd_q        <= 1'b0;
			left_q       <= '0;
		end else begin
			if (cfg_valid) begin
				line_width_q <= line_width;
			end
			if (accept) begin
				if (!col[0]) begin
					left_q <= pixel_in;
				end
				if (last_col) begin
					col_q <= '0;
					odd_q <= !odd;
				end else begin
					col_q <= col + COL_W'(1);
					odd_q <= odd;
				end
			end
		end
	end

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		COL_W'(MAX_WIDTH - 1) >= col_q)
		else $error("column count beyond maximum width");

endmodule

`default_nettype wire

/* sv/rbds_back.sv */
// rbds_back: line store access, 2x2 averaging and result queue
`default_nettype none

module rbds_back #(
	parameter int LINE_DEPTH = 2048,
	parameter int IDX_W      = 11
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       op_empty,
	input  wire logic [IDX_W-1:0]           op_idx,
	input  wire rbds_pkg::op_t              op,
	output logic                            op_pop,
	input  wire logic                       pop,
	output logic                            empty,
	output logic [rbds_pkg::PIX_W-1:0]      pixel_out,
	output logic                            row_end
);

	localparam int OUT_W   = rbds_pkg::PIX_W + 1;
	localparam int OCNT_W  = $clog2(rbds_pkg::OUT_Q_DEPTH + 1);
	localparam int CRED_W  = OCNT_W + 1;

	logic [rbds_pkg::PSUM_W-1:0] line_mem [LINE_DEPTH];

	logic                        valid_s2;
	logic [rbds_pkg::PSUM_W-1:0] rd_s2;
	logic [rbds_pkg::PSUM_W-1:0] psum_s2;
	logic                        row_end_s2;

	logic [OUT_W-1:0]  out_wdata;
	logic [OUT_W-1:0]  out_rdata;
	logic              out_full;
	logic [OCNT_W-1:0] out_count;
	logic [CRED_W-1:0] in_use;
	logic              credit_ok;

	// reserve a result slot for every emit in flight
	assign in_use    = CRED_W'(out_count) + CRED_W'(valid_s2);
	assign credit_ok = in_use < CRED_W'(rbds_pkg::OUT_Q_DEPTH);
	assign op_pop    = !op_empty && (!op.emit || credit_ok);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= op_pop && op.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (op_pop && !op.emit) begin
			line_mem[op_idx] <= op.psum;
		end
		if (op_pop && op.emit) begin
			rd_s2      <= line_mem[op_idx];
			psum_s2    <= op.psum;
			row_end_s2 <= op.row_end;
		end
	end

	assign out_wdata = {row_end_s2, rbds_pkg::avg4(rd_s2, psum_s2)};

	rbds_fifo #(
		.WIDTH(OUT_W),
		.DEPTH(rbds_pkg::OUT_Q_DEPTH)
	) u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (valid_s2),
		.wdata (out_wdata),
		.pop   (pop),
		.rdata (out_rdata),
		.full  (out_full),
		.empty (empty),
		.count (out_count)
	);

	assign pixel_out = out_rdata[rbds_pkg::PIX_W-1:0];
	assign row_end   = out_rdata[OUT_W-1];

	a_no_out_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !out_full)
		else $error("result queue overflow");

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_use <= CRED_W'(rbds_pkg::OUT_Q_DEPTH))
		else $error("results in flight exceed queue space");

	a_s2_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(op_pop && op.emit))
		else $error("result without a preceding emit");

endmodule

`default_nettype wire

/* sv/rgba8_box_downsample_2x2_top.sv */
// rgba8_box_downsample_2x2_top: 2x2 box-filter downsampler for packed rgba8 raster pixels
// throughput: one pixel beat per cycle while full is low, one result per 2x2 block
// a result passes from its closing pixel beat through the op queue, the s2 registers and the result queue
// rate is set by the intake, one pixel beat per edge while full is low; the line store sees one op per pixel pair
// reset: arst_n clears column, row parity, queues and sets line_width to 512
// the line store has no reset; every entry is written on an even row before it is read
`default_nettype none

module rgba8_box_downsample_2x2_top #(
	parameter int MAX_WIDTH = rbds_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// width register write channel
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [rbds_pkg::CFG_W-1:0]   line_width,
	// pixel intake
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [rbds_pkg::PIX_W-1:0]   pixel_in,
	input  wire logic                         frame_start,
	// result side
	output logic                              empty,
	input  wire logic                         pop,
	output logic [rbds_pkg::PIX_W-1:0]        pixel_out,
	output logic                              row_end
);

	// one line store entry per horizontal pixel pair
	localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int IDX_W      = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int OP_W       = IDX_W + $bits(rbds_pkg::op_t);
	localparam int QCNT_W     = $clog2(rbds_pkg::OP_Q_DEPTH + 1);

	// front to queue
	logic                  f_push;
	logic [IDX_W-1:0]      f_idx;
	rbds_pkg::op_t         f_op;
	logic [OP_W-1:0]       q_wdata;

	// queue to back
	logic [OP_W-1:0]       q_rdata;
	logic                  q_full;
	logic                  q_empty;
	logic [QCNT_W-1:0]     q_count;
	logic                  b_pop;
	logic [IDX_W-1:0]      b_idx;
	rbds_pkg::op_t         b_op;

	// front: takes pixel beats, tracks column and row parity, pairs pixels and
	// tags each pair as a line store write (even row) or an emit (odd row)
	rbds_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.IDX_W    (IDX_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.line_width (line_width),
		.push       (push),
		.full       (full),
		.pixel_in   (pixel_in),
		.frame_start(frame_start),
		.op_full    (q_full),
		.op_push    (f_push),
		.op_idx     (f_idx),
		.op         (f_op)
	);

	assign q_wdata = {f_idx, f_op};

	// short op queue decouples pixel intake from line store and result stalls
	rbds_fifo #(
		.WIDTH(OP_W),
		.DEPTH(rbds_pkg::OP_Q_DEPTH)
	) u_op_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_push),
		.wdata (q_wdata),
		.pop   (b_pop),
		.rdata (q_rdata),
		.full  (q_full),
		.empty (q_empty),
		.count (q_count)
	);

	assign b_idx = q_rdata[OP_W-1 -: IDX_W];
	assign b_op  = q_rdata[$bits(rbds_pkg::op_t)-1:0];

	// back: writes pair sums on even rows, reads and averages on odd rows,
	// holds finished pixels in its own result queue
	rbds_back #(
		.LINE_DEPTH(LINE_DEPTH),
		.IDX_W     (IDX_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_empty (q_empty),
		.op_idx   (b_idx),
		.op       (b_op),
		.op_pop   (b_pop),
		.pop      (pop),
		.empty    (empty),
		.pixel_out(pixel_out),
		.row_end  (row_end)
	);

	// the op queue never takes a pair while full
	a_op_q_push: assert property (@(posedge clk) disable iff (!arst_n)
		f_push |-> (q_count != QCNT_W'(rbds_pkg::OP_Q_DEPTH)))
		else $error("op queue overflow");

endmodule

`default_nettype wire
